/* rtl/vertex_attribute_converter_core_macros.svh */
// Assertion macros for the vertex attribute converter.
`ifndef VERTEX_ATTRIBUTE_CONVERTER_CORE_MACROS_SVH
`define VERTEX_ATTRIBUTE_CONVERTER_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define VAC_ASSERT_NOW(lbl, cond, expr) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (expr)) \
        else $error("assertion failed");
`define VAC_ASSERT_NEXT(lbl, cond, expr) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (expr)) \
        else $error("assertion failed");
`else
`define VAC_ASSERT_NOW(lbl, cond, expr)
`define VAC_ASSERT_NEXT(lbl, cond, expr)
`endif
`endif

/* rtl/vac_pkg.sv */
// Package with formats, register indexes and pipeline types of the converter.
`timescale 1ns / 1ps
package vac_pkg;
    localparam logic [2:0] FMT_INT8    = 3'd0;
    localparam logic [2:0] FMT_UINT8   = 3'd1;
    localparam logic [2:0] FMT_INT16   = 3'd2;
    localparam logic [2:0] FMT_UINT16  = 3'd3;
    localparam logic [2:0] FMT_UINT32  = 3'd4;
    localparam logic [2:0] FMT_FLOAT32 = 3'd5;

    localparam logic [1:0] REG_FORMAT    = 2'd0;
    localparam logic [1:0] REG_NORMALIZE = 2'd1;
    localparam logic [1:0] REG_INT_MODE  = 2'd2;

    localparam logic [31:0] POS_ONE_BITS = 32'h3F80_0000;
    localparam logic [31:0] NEG_ONE_BITS = 32'hBF80_0000;
    localparam logic [7:0]  EXP_INT_BASE = 8'd158;
    localparam logic [7:0]  EXP_FRAC_BASE = 8'd126;

    typedef struct packed {
        logic        special;
        logic [31:0] spec_bits;
        logic        unsup;
        logic        sign;
        logic        tail;
        logic [7:0]  expo;
        logic [63:0] frac;
    } stage_t;
endpackage

/* rtl/vertex_attribute_converter_core.sv */
// Vertex attribute component converter: integer and float formats to IEEE single.
//
// Channel   Direction  Handshake         Word contents
// s_        in         s_valid/s_ready   s_raw_component
// m_        out        m_valid/m_ready   m_value_bits, m_unsupported
// apb       in         psel/penable      component_format, normalize_enable, integer_mode
//
// A word passes four register stages: decode, two halves of the normalizing shift,
// and rounding. One word is accepted every cycle while the stages are not held; a stage
// holds when the stage after it is full and held.
// Reset is synchronous on aresetn: valid bits and mode bits clear, format goes to float32.
// A stalled result keeps its value and the stages behind it fill up and hold.
`timescale 1ns / 1ps
`include "vertex_attribute_converter_core_macros.svh"
module vertex_attribute_converter_core
    import vac_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_raw_component,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_value_bits,
    output logic        m_unsupported
);
    logic [2:0]  fmt_reg;
    logic        norm_reg;
    logic        imode_reg;
    logic        v1_reg, v2_reg, v3_reg, vo_reg;
    stage_t      s1_reg, s1_next, s2_reg, s2_next, s3_reg, s3_next;
    logic [31:0] val_reg, val_next;
    logic        uns_reg, uns_next;
    logic        en1, en2, en3, eno;
    logic [7:0]  m8;
    logic [15:0] m16;
    logic [1:0]  ridx;
    logic        guard, sticky, rup;

    assign pready = 1'b1;
    assign ridx   = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg   <= FMT_FLOAT32;
            norm_reg  <= 1'b0;
            imode_reg <= 1'b0;
        end else if (psel && penable && pwrite) begin
            unique case (ridx)
                REG_FORMAT:    fmt_reg   <= pwdata[2:0];
                REG_NORMALIZE: norm_reg  <= pwdata[0];
                REG_INT_MODE:  imode_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (ridx)
            REG_FORMAT:    prdata = {29'd0, fmt_reg};
            REG_NORMALIZE: prdata = {31'd0, norm_reg};
            REG_INT_MODE:  prdata = {31'd0, imode_reg};
            default:       prdata = 32'd0;
        endcase
    end

    assign eno     = !vo_reg || m_ready;
    assign en3     = !v3_reg || eno;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1;

    assign m8  = s_raw_component[7] ? 8'(~s_raw_component[7:0] + 8'd1)
                                    : s_raw_component[7:0];
    assign m16 = s_raw_component[15] ? 16'(~s_raw_component[15:0] + 16'd1)
                                     : s_raw_component[15:0];

    always_comb begin
        s1_next = '0;
        if (imode_reg) begin
            s1_next.special = 1'b1;
            case (fmt_reg)
                FMT_UINT8:  s1_next.spec_bits = {24'd0, s_raw_component[7:0]};
                FMT_UINT16: s1_next.spec_bits = {16'd0, s_raw_component[15:0]};
                FMT_UINT32: s1_next.spec_bits = s_raw_component;
                default:    s1_next.unsup = 1'b1;
            endcase
        end else begin
            case (fmt_reg)
                FMT_INT8: begin
                    s1_next.sign = s_raw_component[7];
                    if (m8 == 8'd0) begin
                        s1_next.special = 1'b1;
                    end else if (norm_reg) begin
                        if (m8 > 8'd127) begin
                            s1_next.special   = 1'b1;
                            s1_next.spec_bits = NEG_ONE_BITS;
                        end else if (m8 == 8'd127) begin
                            s1_next.special   = 1'b1;
                            s1_next.spec_bits = s_raw_component[7] ? NEG_ONE_BITS
                                                                   : POS_ONE_BITS;
                        end else begin
                            s1_next.frac = {{9{m8[6:0]}}, 1'b0};
                            s1_next.expo = EXP_FRAC_BASE;
                            s1_next.tail = 1'b1;
                        end
                    end else begin
                        s1_next.frac = {24'd0, m8, 32'd0};
                        s1_next.expo = EXP_INT_BASE;
                    end
                end
                FMT_UINT8: begin
                    if (s_raw_component[7:0] == 8'd0) begin
                        s1_next.special = 1'b1;
                    end else if (norm_reg) begin
                        if (s_raw_component[7:0] == 8'hFF) begin
                            s1_next.special   = 1'b1;
                            s1_next.spec_bits = POS_ONE_BITS;
                        end else begin
                            s1_next.frac = {8{s_raw_component[7:0]}};
                            s1_next.expo = EXP_FRAC_BASE;
                            s1_next.tail = 1'b1;
                        end
                    end else begin
                        s1_next.frac = {24'd0, s_raw_component[7:0], 32'd0};
                        s1_next.expo = EXP_INT_BASE;
                    end
                end
                FMT_INT16: begin
                    s1_next.sign = s_raw_component[15];
                    if (m16 == 16'd0) begin
                        s1_next.special = 1'b1;
                    end else if (norm_reg) begin
                        if (m16 > 16'd32767) begin
                            s1_next.special   = 1'b1;
                            s1_next.spec_bits = NEG_ONE_BITS;
                        end else if (m16 == 16'd32767) begin
                            s1_next.special   = 1'b1;
                            s1_next.spec_bits = s_raw_component[15] ? NEG_ONE_BITS
                                                                    : POS_ONE_BITS;
                        end else begin
                            s1_next.frac = {{4{m16[14:0]}}, 4'd0};
                            s1_next.expo = EXP_FRAC_BASE;
                            s1_next.tail = 1'b1;
                        end
                    end else begin
                        s1_next.frac = {16'd0, m16, 32'd0};
                        s1_next.expo = EXP_INT_BASE;
                    end
                end
                FMT_UINT16: begin
                    if (s_raw_component[15:0] == 16'd0) begin
                        s1_next.special = 1'b1;
                    end else if (norm_reg) begin
                        if (s_raw_component[15:0] == 16'hFFFF) begin
                            s1_next.special   = 1'b1;
                            s1_next.spec_bits = POS_ONE_BITS;
                        end else begin
                            s1_next.frac = {4{s_raw_component[15:0]}};
                            s1_next.expo = EXP_FRAC_BASE;
                            s1_next.tail = 1'b1;
                        end
                    end else begin
                        s1_next.frac = {16'd0, s_raw_component[15:0], 32'd0};
                        s1_next.expo = EXP_INT_BASE;
                    end
                end
                FMT_UINT32: begin
                    if (s_raw_component == 32'd0) begin
                        s1_next.special = 1'b1;
                    end else begin
                        s1_next.frac = {s_raw_component, 32'd0};
                        s1_next.expo = EXP_INT_BASE;
                    end
                end
                FMT_FLOAT32: begin
                    s1_next.special   = 1'b1;
                    s1_next.spec_bits = s_raw_component;
                end
                default: s1_next.special = 1'b1;
            endcase
        end
    end

    always_comb begin
        s2_next = s1_reg;
        if (s2_next.frac[63:32] == 32'd0) begin
            s2_next.frac = {s2_next.frac[31:0], 32'd0};
            s2_next.expo = s2_next.expo - 8'd32;
        end
        if (s2_next.frac[63:48] == 16'd0) begin
            s2_next.frac = {s2_next.frac[47:0], 16'd0};
            s2_next.expo = s2_next.expo - 8'd16;
        end
        if (s2_next.frac[63:56] == 8'd0) begin
            s2_next.frac = {s2_next.frac[55:0], 8'd0};
            s2_next.expo = s2_next.expo - 8'd8;
        end
    end

    always_comb begin
        s3_next = s2_reg;
        if (s3_next.frac[63:60] == 4'd0) begin
            s3_next.frac = {s3_next.frac[59:0], 4'd0};
            s3_next.expo = s3_next.expo - 8'd4;
        end
        if (s3_next.frac[63:62] == 2'd0) begin
            s3_next.frac = {s3_next.frac[61:0], 2'd0};
            s3_next.expo = s3_next.expo - 8'd2;
        end
        if (!s3_next.frac[63]) begin
            s3_next.frac = {s3_next.frac[62:0], 1'b0};
            s3_next.expo = s3_next.expo - 8'd1;
        end
    end

    assign guard  = s3_reg.frac[39];
    assign sticky = (|s3_reg.frac[38:0]) || s3_reg.tail;
    assign rup    = guard && (sticky || s3_reg.frac[40]);

    always_comb begin
        uns_next = s3_reg.unsup;
        if (s3_reg.special) begin
            val_next = s3_reg.spec_bits;
        end else begin
            val_next = {s3_reg.sign, s3_reg.expo, s3_reg.frac[62:40]} + {31'd0, rup};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (eno) vo_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) s1_reg <= s1_next;
        if (en2) s2_reg <= s2_next;
        if (en3) s3_reg <= s3_next;
        if (eno) begin
            val_reg <= val_next;
            uns_reg <= uns_next;
        end
    end

    assign m_valid       = vo_reg;
    assign m_value_bits  = val_reg;
    assign m_unsupported = uns_reg;

    `VAC_ASSERT_NOW(a_unsup_zero, m_valid && m_unsupported, m_value_bits == 32'd0)
    `VAC_ASSERT_NEXT(a_accept_fills, s_valid && s_ready, v1_reg)
    `VAC_ASSERT_NEXT(a_stage_holds, v3_reg && !eno, v3_reg && $stable(s3_reg))
endmodule

/* tb/vertex_attribute_converter_core_tb.sv */
// Testbench for the vertex attribute converter: directed table, random phases, self-checking.
`timescale 1ns / 1ps
module vertex_attribute_converter_core_tb;
    import vac_pkg::*;

    localparam int RAND_WORDS  = 1050;
    localparam int CHUNK_WORDS = 70;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [31:0] value;
        logic        unsup;
    } conv_t;

    typedef struct {
        logic [2:0]  fmt;
        logic        norm;
        logic        imode;
        logic [31:0] raw;
        bit          typed;
        logic [31:0] exp_value;
        logic        exp_unsup;
    } row_t;

    logic        aclk;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_raw_component;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_value_bits;
    logic        m_unsupported;

    logic [2:0] cfg_format;
    logic       cfg_normalize;
    logic       cfg_int_mode;
    int         send_idle_pct;
    int         recv_stall_pct;
    int         mismatches;
    int         cycles;
    conv_t      pending_words[$];
    row_t       rows[$];

    vertex_attribute_converter_core dut (.*);

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic logic [31:0] ratio_bits(bit neg, logic [31:0] mag, logic [31:0] div);
        logic [127:0] num;
        logic [127:0] quo;
        logic [127:0] rmd;
        logic [127:0] rest;
        logic [127:0] half;
        logic [31:0]  mant;
        logic [8:0]   ex;
        int           msb;
        int           sh;
        bit           up;
        if (mag == 0) return 32'd0;
        num = {96'd0, mag} << 60;
        quo = num / div;
        rmd = num % div;
        msb = 0;
        for (int i = 0; i < 128; i++) if (quo[i]) msb = i;
        sh   = msb - 23;
        mant = 32'(quo >> sh);
        rest = quo & ((128'd1 << sh) - 1);
        half = 128'd1 << (sh - 1);
        up   = (rest > half) || (rest == half && (rmd != 0 || mant[0]));
        mant = mant + up;
        ex   = 9'(msb - 60 + 127);
        if (mant[24]) begin
            mant = mant >> 1;
            ex   = ex + 1;
        end
        return {neg, ex[7:0], mant[22:0]};
    endfunction

    function automatic logic [31:0] signed_bits(logic [31:0] sval, int width, bit norm,
                                                logic [31:0] div);
        bit          neg;
        logic [31:0] mag;
        neg = sval[width-1];
        mag = neg ? ((32'd1 << width) - (sval & ((32'd1 << width) - 1)))
                  : (sval & ((32'd1 << width) - 1));
        if (!norm) return ratio_bits(neg, mag, 32'd1);
        if (neg && mag > div) return NEG_ONE_BITS;
        return ratio_bits(neg, mag, div);
    endfunction

    function automatic conv_t convert(logic [2:0] fmt, logic norm, logic imode,
                                      logic [31:0] raw);
        conv_t r;
        r.value = 32'd0;
        r.unsup = 1'b0;
        if (imode) begin
            case (fmt)
                FMT_UINT8:  r.value = {24'd0, raw[7:0]};
                FMT_UINT16: r.value = {16'd0, raw[15:0]};
                FMT_UINT32: r.value = raw;
                default:    r.unsup = 1'b1;
            endcase
        end else begin
            case (fmt)
                FMT_INT8:    r.value = signed_bits(raw, 8, norm, 32'd127);
                FMT_UINT8:   r.value = ratio_bits(0, {24'd0, raw[7:0]}, norm ? 32'd255 : 32'd1);
                FMT_INT16:   r.value = signed_bits(raw, 16, norm, 32'd32767);
                FMT_UINT16:  r.value = ratio_bits(0, {16'd0, raw[15:0]},
                                                  norm ? 32'd65535 : 32'd1);
                FMT_UINT32:  r.value = ratio_bits(0, raw, 32'd1);
                FMT_FLOAT32: r.value = raw;
                default:     r.value = 32'd0;
            endcase
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("vertex_attribute_converter_core verification failed");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        conv_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_words.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("Unexpected word: value %h unsupported %b",
                             m_value_bits, m_unsupported);
            end else begin
                want = pending_words.pop_front();
                if (m_value_bits !== want.value || m_unsupported !== want.unsup) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("Mismatch: expected %h/%b, got %h/%b", want.value,
                                 want.unsup, m_value_bits, m_unsupported);
                end
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        @(negedge aclk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        pwdata  = data;
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic drain();
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic set_config(logic [2:0] fmt, logic norm, logic imode);
        @(negedge aclk);
        s_valid = 1'b0;
        drain();
        write_reg(REG_FORMAT, {29'd0, fmt});
        write_reg(REG_NORMALIZE, {31'd0, norm});
        write_reg(REG_INT_MODE, {31'd0, imode});
        cfg_format    = fmt;
        cfg_normalize = norm;
        cfg_int_mode  = imode;
    endtask

    task automatic send_word(logic [31:0] raw, conv_t want);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid         = 1'b1;
        s_raw_component = raw;
        @(posedge aclk iff s_ready);
        pending_words = {pending_words, want};
    endtask

    task automatic add_row(logic [2:0] fmt, logic norm, logic imode, logic [31:0] raw,
                           bit typed, logic [31:0] ev, logic eu);
        row_t r;
        r = '{fmt, norm, imode, raw, typed, ev, eu};
        rows = {rows, r};
    endtask

    initial begin
        row_t        r;
        conv_t       want;
        logic [31:0] raw;
        aresetn = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        s_valid = 1'b0; s_raw_component = '0; m_ready = 1'b0;
        mismatches = 0; cycles = 0;
        send_idle_pct = 0; recv_stall_pct = 0;
        cfg_format = FMT_FLOAT32; cfg_normalize = 1'b0; cfg_int_mode = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        add_row(FMT_FLOAT32, 0, 0, 32'hDEAD_BEEF, 1, 32'hDEAD_BEEF, 0);
        add_row(FMT_FLOAT32, 1, 0, 32'h7FC0_0001, 1, 32'h7FC0_0001, 0);
        add_row(FMT_INT8, 1, 0, 32'hFFFF_FF80, 1, NEG_ONE_BITS, 0);
        add_row(FMT_INT8, 1, 0, 32'h0000_007F, 1, POS_ONE_BITS, 0);
        add_row(FMT_INT8, 1, 0, 32'h0000_0081, 1, NEG_ONE_BITS, 0);
        add_row(FMT_INT8, 0, 0, 32'h1234_5680, 0, 0, 0);
        add_row(FMT_INT16, 1, 0, 32'hABCD_8000, 1, NEG_ONE_BITS, 0);
        add_row(FMT_INT16, 1, 0, 32'h0000_7FFF, 1, POS_ONE_BITS, 0);
        add_row(FMT_INT16, 0, 0, 32'h0001_2345, 0, 0, 0);
        add_row(FMT_UINT8, 1, 0, 32'hFFFF_FFFF, 1, POS_ONE_BITS, 0);
        add_row(FMT_UINT8, 0, 0, 32'hFFFF_FF00, 1, 32'd0, 0);
        add_row(FMT_UINT16, 1, 0, 32'h0000_FFFF, 1, POS_ONE_BITS, 0);
        add_row(FMT_UINT16, 1, 0, 32'h0000_1234, 0, 0, 0);
        add_row(FMT_UINT32, 1, 0, 32'hFFFF_FFFF, 1, 32'h4F80_0000, 0);
        add_row(FMT_UINT32, 0, 0, 32'h0000_0001, 1, POS_ONE_BITS, 0);
        add_row(FMT_UINT32, 0, 0, 32'h0123_4567, 0, 0, 0);
        add_row(3'd6, 1, 0, 32'hFFFF_FFFF, 1, 32'd0, 0);
        add_row(3'd7, 0, 1, 32'hFFFF_FFFF, 1, 32'd0, 1);
        add_row(FMT_INT8, 0, 1, 32'h0000_0055, 1, 32'd0, 1);
        add_row(FMT_INT16, 1, 1, 32'h0000_5555, 1, 32'd0, 1);
        add_row(FMT_FLOAT32, 0, 1, 32'h3F80_0000, 1, 32'd0, 1);
        add_row(FMT_UINT8, 1, 1, 32'hABCD_EF12, 1, 32'h0000_0012, 0);
        add_row(FMT_UINT16, 0, 1, 32'hABCD_EF12, 1, 32'h0000_EF12, 0);
        add_row(FMT_UINT32, 0, 1, 32'hABCD_EF12, 1, 32'hABCD_EF12, 0);

        foreach (rows[i]) begin
            r = rows[i];
            if (i != 0) set_config(r.fmt, r.norm, r.imode);
            want = r.typed ? conv_t'{r.exp_value, r.exp_unsup}
                           : convert(cfg_format, cfg_normalize, cfg_int_mode, r.raw);
            send_word(r.raw, want);
        end

        for (int n = 0; n < RAND_WORDS; n++) begin
            if (n % CHUNK_WORDS == 0) begin
                @(negedge aclk);
                s_valid = 1'b0;
                case ((n / CHUNK_WORDS) % 4)
                    0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                    1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
                    2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
                    default: begin send_idle_pct = 19; recv_stall_pct = 19; end
                endcase
                set_config(($urandom_range(99) < 8) ? 3'(6 + $urandom_range(1))
                                                    : 3'($urandom_range(5)),
                           1'($urandom_range(1)), 1'($urandom_range(3) == 0));
            end
            case ($urandom_range(3))
                0: raw = $urandom;
                1: raw = ($urandom & 32'hFFFF_FF00) | (32'h7F + $urandom_range(2));
                2: raw = ($urandom & 32'hFFFF_0000) | (32'h7FFF + $urandom_range(2));
                default: raw = $urandom_range(3);
            endcase
            send_word(raw, convert(cfg_format, cfg_normalize, cfg_int_mode, raw));
        end
        @(negedge aclk);
        s_valid = 1'b0;
        drain();

        if (mismatches == 0 && pending_words.size() == 0)
            $display("vertex_attribute_converter_core verification clean");
        else
            $display("vertex_attribute_converter_core verification failed");
        $finish;
    end
endmodule
